// ===== rtl/tsas_pkg.sv =====
// ----------------------------------------------------------------------------
// Touch sample averaging and scaling: shared package
// Widths, screen limits, register indexes and item types for the block.
// ----------------------------------------------------------------------------
package tsas_pkg;

	localparam int MAX_SAMPLES   = 10;
	localparam int SCREEN_WIDTH  = 240;
	localparam int SCREEN_HEIGHT = 320;

	localparam int SAMPLE_W   = 12;
	localparam int COUNT_W    = 4;
	localparam int OFFSET_W   = 13;
	localparam int GAIN_W     = 17;
	localparam int ORIENT_W   = 3;
	localparam int XPOS_W     = 8;
	localparam int YPOS_W     = 9;
	localparam int LIMIT_W    = 12;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 17;

	// Bit positions within the orientation register.
	localparam int ORIENT_SWAP     = 0;
	localparam int ORIENT_MIRROR_X = 1;
	localparam int ORIENT_MIRROR_Y = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_X_OFFSET    = 3'd0,
		REG_Y_OFFSET    = 3'd1,
		REG_X_GAIN      = 3'd2,
		REG_Y_GAIN      = 3'd3,
		REG_ORIENTATION = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] x_sample;
		logic [SAMPLE_W-1:0] y_sample;
	} in_item_t;

	typedef struct packed {
		logic [XPOS_W-1:0] x_pos;
		logic [YPOS_W-1:0] y_pos;
	} out_item_t;

	typedef struct packed {
		logic signed [OFFSET_W-1:0] x_offset;
		logic signed [OFFSET_W-1:0] y_offset;
		logic signed [GAIN_W-1:0]   x_gain;
		logic signed [GAIN_W-1:0]   y_gain;
		logic [ORIENT_W-1:0]        orientation;
	} cfg_t;

	// Load enables for the scaling stages.
	typedef struct packed {
		logic en_s2;
		logic en_s3;
	} pipe_ctrl_t;

endpackage

// ===== rtl/tsas_cfg.sv =====
// ----------------------------------------------------------------------------
// Touch sample averaging and scaling: configuration registers
// Holds offsets, gains and orientation, written through the config channel.
// ----------------------------------------------------------------------------
module tsas_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [tsas_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tsas_pkg::CFG_DATA_W-1:0]  cfg_data,
	output tsas_pkg::cfg_t                   cfg
);
	import tsas_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.x_offset    <= '0;
			cfg_q.y_offset    <= '0;
			cfg_q.x_gain      <= GAIN_W'(4369);
			cfg_q.y_gain      <= GAIN_W'(3277);
			cfg_q.orientation <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_X_OFFSET:    cfg_q.x_offset    <= cfg_data[OFFSET_W-1:0];
				REG_Y_OFFSET:    cfg_q.y_offset    <= cfg_data[OFFSET_W-1:0];
				REG_X_GAIN:      cfg_q.x_gain      <= cfg_data[GAIN_W-1:0];
				REG_Y_GAIN:      cfg_q.y_gain      <= cfg_data[GAIN_W-1:0];
				REG_ORIENTATION: cfg_q.orientation <= cfg_data[ORIENT_W-1:0];
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== rtl/tsas_avg.sv =====
// ----------------------------------------------------------------------------
// Touch sample averaging and scaling: burst averaging
// Keeps the running values and sample count and decides when a burst ends.
// ----------------------------------------------------------------------------
module tsas_avg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           accept,
	input  tsas_pkg::in_item_t             in_item,
	input  logic                           swap,
	input  logic                           take_s1,
	output logic                           valid_s1,
	output logic [tsas_pkg::SAMPLE_W-1:0]  px_s1,
	output logic [tsas_pkg::SAMPLE_W-1:0]  py_s1
);
	import tsas_pkg::*;

	logic [SAMPLE_W-1:0] avg_x_q, avg_y_q;
	logic [COUNT_W-1:0]  count_q;
	logic                valid_s1_q;
	logic [SAMPLE_W:0]   sum_x, sum_y;
	logic [SAMPLE_W-1:0] nx, ny;
	logic [SAMPLE_W:0]   dx, dy;
	logic [COUNT_W-1:0]  count_next;
	logic                settled, emit;

	always_comb begin
		sum_x      = {1'b0, avg_x_q} + {1'b0, in_item.x_sample};
		sum_y      = {1'b0, avg_y_q} + {1'b0, in_item.y_sample};
		nx         = sum_x[SAMPLE_W:1];
		ny         = sum_y[SAMPLE_W:1];
		// The new value always lies toward the sample, so one signed
		// difference per axis covers both directions.
		dx         = {1'b0, avg_x_q} - {1'b0, nx};
		dy         = {1'b0, avg_y_q} - {1'b0, ny};
		settled    = ($signed(dx) <= 2'sd1) && ($signed(dx) >= -2'sd1) &&
		             ($signed(dy) <= 2'sd1) && ($signed(dy) >= -2'sd1);
		count_next = count_q + COUNT_W'(1);
		emit       = (count_q != '0) &&
		             (settled || (count_next >= COUNT_W'(MAX_SAMPLES)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_x_q    <= '0;
			avg_y_q    <= '0;
			count_q    <= '0;
			valid_s1_q <= 1'b0;
		end else begin
			if (accept) begin
				if (count_q == '0) begin
					avg_x_q <= in_item.x_sample;
					avg_y_q <= in_item.y_sample;
					count_q <= COUNT_W'(1);
				end else begin
					avg_x_q <= nx;
					avg_y_q <= ny;
					count_q <= emit ? '0 : count_next;
				end
			end
			if (accept && emit) begin
				valid_s1_q <= 1'b1;
			end else if (take_s1) begin
				valid_s1_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			px_s1 <= swap ? ny : nx;
			py_s1 <= swap ? nx : ny;
		end
	end

	assign valid_s1 = valid_s1_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q < COUNT_W'(MAX_SAMPLES))
		else $error("burst sample count out of range");

	a_emit_not_seed: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && count_q == '0) |=> (count_q == COUNT_W'(1)))
		else $error("seed sample did not start a burst");

endmodule

// ===== rtl/tsas_scale.sv =====
// ----------------------------------------------------------------------------
// Touch sample averaging and scaling: axis scaler
// Offset subtract and gain multiply, then clamp to the screen and mirror.
// ----------------------------------------------------------------------------
module tsas_scale (
	input  logic                                 clk,
	input  tsas_pkg::pipe_ctrl_t                 ctrl,
	input  logic [tsas_pkg::SAMPLE_W-1:0]        raw_s1,
	input  logic signed [tsas_pkg::OFFSET_W-1:0] offset,
	input  logic signed [tsas_pkg::GAIN_W-1:0]   gain,
	input  logic [tsas_pkg::LIMIT_W-1:0]         limit,
	input  logic                                 mirror,
	output logic [tsas_pkg::LIMIT_W-1:0]         pos_s3
);
	import tsas_pkg::*;

	localparam int DIFF_W = SAMPLE_W + 2;
	localparam int PROD_W = DIFF_W + GAIN_W;

	logic signed [DIFF_W-1:0] diff;
	logic signed [PROD_W-1:0] prod_s2;
	logic [PROD_W-18:0]       quot;
	logic [LIMIT_W-1:0]       clamped;

	assign diff = $signed({2'b00, raw_s1}) - DIFF_W'(offset);

	always_comb begin
		quot = prod_s2[PROD_W-2:16];
		// Dropping the low bits of a negative product rounds it down, so it never goes above
		// zero, and every negative product clamps straight to zero.
		if (prod_s2[PROD_W-1]) begin
			clamped = '0;
		end else if (quot > (PROD_W-17)'(limit)) begin
			clamped = limit;
		end else begin
			clamped = quot[LIMIT_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.en_s2) begin
			prod_s2 <= PROD_W'(diff) * PROD_W'(gain);
		end
		if (ctrl.en_s3) begin
			pos_s3 <= mirror ? (limit - clamped) : clamped;
		end
	end

endmodule

// ===== rtl/touch_sample_average_and_scale_unit.sv =====
// ----------------------------------------------------------------------------
// Touch sample averaging and scaling unit
// Averages bursts of raw X/Y samples and turns the settled value into a
// clamped, optionally swapped and mirrored screen position.
// ----------------------------------------------------------------------------
// A result passes from the averaging register to the product register and then to the
// position register before it is presented; each can hold it while the output stalls.
// Throughput: one sample per cycle; the input stalls only when all three
// result stages are full and the output is stalled.
// Reset: running values and count clear, the burst restarts with the next
// sample, and the registers return to offset 0, gains 4369 and 3277, no
// swap and no mirror.
module touch_sample_average_and_scale_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  tsas_pkg::in_item_t              in_item,
	output logic                            out_valid,
	input  logic                            out_stall,
	output tsas_pkg::out_item_t             out_item,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [tsas_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tsas_pkg::CFG_DATA_W-1:0] cfg_data
);
	import tsas_pkg::*;

	cfg_t                cfg;
	pipe_ctrl_t          ctrl;
	logic                accept, valid_s1, valid_s2_q, valid_s3_q;
	logic                adv2, adv3;
	logic [SAMPLE_W-1:0] px_s1, py_s1;
	logic [LIMIT_W-1:0]  x_pos_s3, y_pos_s3;

	assign adv3       = !valid_s3_q || !out_stall;
	assign adv2       = !valid_s2_q || adv3;
	assign in_stall   = valid_s1 && !adv2;
	assign accept     = in_valid && !in_stall;
	assign ctrl.en_s2 = valid_s1 && adv2;
	assign ctrl.en_s3 = valid_s2_q && adv3;

	tsas_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	tsas_avg u_avg (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.in_item  (in_item),
		.swap     (cfg.orientation[ORIENT_SWAP]),
		.take_s1  (adv2),
		.valid_s1 (valid_s1),
		.px_s1    (px_s1),
		.py_s1    (py_s1)
	);

	tsas_scale u_scale_x (
		.clk    (clk),
		.ctrl   (ctrl),
		.raw_s1 (px_s1),
		.offset (cfg.x_offset),
		.gain   (cfg.x_gain),
		.limit  (LIMIT_W'(SCREEN_WIDTH)),
		.mirror (cfg.orientation[ORIENT_MIRROR_X]),
		.pos_s3 (x_pos_s3)
	);

	tsas_scale u_scale_y (
		.clk    (clk),
		.ctrl   (ctrl),
		.raw_s1 (py_s1),
		.offset (cfg.y_offset),
		.gain   (cfg.y_gain),
		.limit  (LIMIT_W'(SCREEN_HEIGHT)),
		.mirror (cfg.orientation[ORIENT_MIRROR_Y]),
		.pos_s3 (y_pos_s3)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2_q <= 1'b0;
			valid_s3_q <= 1'b0;
		end else begin
			if (adv2) begin
				valid_s2_q <= valid_s1;
			end
			if (adv3) begin
				valid_s3_q <= valid_s2_q;
			end
		end
	end

	assign out_valid      = valid_s3_q;
	assign out_item.x_pos = x_pos_s3[XPOS_W-1:0];
	assign out_item.y_pos = y_pos_s3[YPOS_W-1:0];

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2_q && valid_s3_q && out_stall))
		else $error("input stalled while a result stage was free");

	a_x_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (x_pos_s3 <= LIMIT_W'(SCREEN_WIDTH)))
		else $error("x position beyond screen width");

	a_y_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (y_pos_s3 <= LIMIT_W'(SCREEN_HEIGHT)))
		else $error("y position beyond screen height");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3_q && !out_stall && !valid_s2_q) |=> !valid_s3_q)
		else $error("delivered result was repeated");

	a_s2_move: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.en_s2 |=> valid_s2_q)
		else $error("loaded product stage lost its item");

endmodule
